### sv/mewf_pkg.sv
package mewf_pkg;

    // defaults for the top-level parameters
    localparam int DEF_WINDOW        = 5;
    localparam int DEF_SAMPLE_BITS   = 24;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int ALPHA_BITS = 17;
    localparam int OUT_BITS   = 24;
    localparam int BUS_BITS   = 32;
    localparam int ADDR_BITS  = 3;

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 17'd13107;

    // register select (word address bit)
    localparam logic REG_TARE  = 1'b0;
    localparam logic REG_ALPHA = 1'b1;

    // request classes passed from front to back
    typedef logic [1:0] op_t;
    localparam op_t OP_FEED   = 2'd0;
    localparam op_t OP_REJECT = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;

endpackage

### sv/mewf_front.sv
module mewf_front
    import mewf_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic                          command,
    input  logic signed [SAMPLE_BITS-1:0] raw_sample,
    input  logic signed [SAMPLE_BITS-1:0] tare_offset,
    output logic                          q_valid,
    input  logic                          q_take,
    output op_t                           q_op,
    output logic [SAMPLE_BITS-1:0]        q_value
);

    logic signed [SAMPLE_BITS:0] corrected;
    op_t                         op_in;
    logic                        push;

    op_t                   op_mem   [2];
    logic [SAMPLE_BITS-1:0] val_mem [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;

    // offset correction and classification
    assign corrected = $signed({raw_sample[SAMPLE_BITS-1], raw_sample})
                     - $signed({tare_offset[SAMPLE_BITS-1], tare_offset});

    always_comb
    begin
        if (command)
            op_in = OP_CLEAR;
        else if (corrected[SAMPLE_BITS])
            op_in = OP_REJECT;
        else
            op_in = OP_FEED;
    end

    // two-entry queue
    assign sample_stall = (count_reg == 2'd2);
    assign push         = sample_valid && !sample_stall;
    assign q_valid      = (count_reg != 2'd0);
    assign q_op         = op_mem[rd_ptr_reg];
    assign q_value      = val_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]  <= op_in;
            val_mem[wr_ptr_reg] <= corrected[SAMPLE_BITS-1:0];
        end
    end

endmodule

### sv/mewf_blend.sv
module mewf_blend
    import mewf_pkg::*;
#(
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ALPHA_BITS-1:0]               alpha,
    input  logic [SAMPLE_BITS+FRACTION_BITS-1:0] median,
    input  logic [SAMPLE_BITS+FRACTION_BITS-1:0] average,
    output logic                                done,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0] result
);

    // avg' = avg + (alpha * (median - avg)) >>> 16, product built 16 bits a step
    localparam int AVG_W = SAMPLE_BITS + FRACTION_BITS;
    localparam int D_W   = AVG_W + 1;
    localparam int NCH   = (D_W + 15) / 16;
    localparam int PAD_W = NCH * 16;
    localparam int ACC_W = PAD_W + 18;
    localparam int CNT_W = $clog2(NCH + 1);
    localparam int SEL_W = $clog2(NCH);
    localparam int PRD_W = ALPHA_BITS + 1 + 17;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [ALPHA_BITS-1:0]   a_reg;
    logic [AVG_W-1:0]        v_reg;
    logic signed [PAD_W-1:0] d_reg;
    logic signed [PRD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [D_W-1:0]   diff;
    logic [SEL_W-1:0]        sel;
    logic [15:0]             chunk_raw;
    logic signed [16:0]      chunk;
    logic signed [PRD_W-1:0] mult;
    logic signed [ACC_W-1:0] shifted;
    logic [ACC_W-1:0]        total;
    logic                    last;

    assign diff = $signed({1'b0, median}) - $signed({1'b0, average});
    assign last = (cnt_reg == CNT_W'(NCH));

    // most significant chunk first; only the top one carries the sign
    always_comb
    begin
        sel       = last ? '0 : SEL_W'(NCH - 1) - cnt_reg[SEL_W-1:0];
        chunk_raw = d_reg[sel*16 +: 16];
        if (cnt_reg == '0)
            chunk = $signed({chunk_raw[15], chunk_raw});
        else
            chunk = $signed({1'b0, chunk_raw});
    end

    assign mult = $signed({1'b0, a_reg}) * chunk;

    assign shifted = acc_reg >>> 16;
    assign total   = ACC_W'(v_reg) + $unsigned(shifted);
    assign result  = total[AVG_W-1:0];
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= alpha;
            v_reg    <= average;
            d_reg    <= PAD_W'(diff);
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (!last)
                prod_reg <= mult;
            acc_reg <= (acc_reg <<< 16) + ACC_W'(prod_reg);
        end
    end

endmodule

### sv/mewf_back.sv
module mewf_back
    import mewf_pkg::*;
#(
    parameter int WINDOW        = DEF_WINDOW,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_take,
    input  op_t                    q_op,
    input  logic [SAMPLE_BITS-1:0] q_value,
    input  logic [ALPHA_BITS-1:0]  alpha,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [OUT_BITS-1:0]    filtered_weight,
    output logic                   sample_rejected,
    output logic                   average_valid
);

    localparam int AVG_W = SAMPLE_BITS + FRACTION_BITS;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_BLEND = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] ring_reg [WINDOW];
    logic [IDX_W-1:0]       wpos_reg, wpos_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]       cand_reg, cand_next;
    logic [AVG_W-1:0]       avg_reg, avg_next;
    logic                   seeded_reg, seeded_next;
    logic                   rej_reg, rej_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]    weight_reg, weight_next;
    logic                   out_rej_reg, out_rej_next;
    logic                   out_seeded_reg, out_seeded_next;

    logic                   ring_we;
    logic [SAMPLE_BITS-1:0] cand_val;
    logic [CNT_W-1:0]       below, not_above, half;
    logic                   hit, last;
    logic [AVG_W-1:0]       med_fx;
    logic [ALPHA_BITS-1:0]  alpha_sat;
    logic                   blend_start, blend_done;
    logic [AVG_W-1:0]       blend_result;

    // rank test of one candidate against the filled entries
    always_comb
    begin
        cand_val  = ring_reg[cand_reg];
        below     = '0;
        not_above = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if (CNT_W'(j) < fill_reg)
            begin
                below     = below + CNT_W'(ring_reg[j] < cand_val);
                not_above = not_above + CNT_W'(ring_reg[j] <= cand_val);
            end
        end
    end

    assign half      = fill_reg >> 1;
    assign hit       = (below <= half) && (half < not_above);
    assign last      = (cand_reg == IDX_W'(fill_reg - CNT_W'(1)));
    assign med_fx    = {cand_val, {FRACTION_BITS{1'b0}}};
    assign alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

    mewf_blend #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (blend_start),
        .alpha   (alpha_sat),
        .median  (med_fx),
        .average (avg_reg),
        .done    (blend_done),
        .result  (blend_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        wpos_next       = wpos_reg;
        fill_next       = fill_reg;
        cand_next       = cand_reg;
        avg_next        = avg_reg;
        seeded_next     = seeded_reg;
        rej_next        = rej_reg;
        out_valid_next  = out_valid_reg;
        weight_next     = weight_reg;
        out_rej_next    = out_rej_reg;
        out_seeded_next = out_seeded_reg;
        q_take          = 1'b0;
        ring_we         = 1'b0;
        blend_start     = 1'b0;

        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    unique case (q_op)
                        OP_CLEAR:
                        begin
                            wpos_next   = '0;
                            fill_next   = '0;
                            avg_next    = '0;
                            seeded_next = 1'b0;
                            rej_next    = 1'b0;
                            state_next  = ST_EMIT;
                        end
                        OP_FEED:
                        begin
                            ring_we   = 1'b1;
                            wpos_next = (wpos_reg == IDX_W'(WINDOW - 1))
                                      ? '0 : wpos_reg + IDX_W'(1);
                            if (fill_reg < CNT_W'(WINDOW))
                                fill_next = fill_reg + CNT_W'(1);
                            cand_next  = '0;
                            rej_next   = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            rej_next   = 1'b1;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit || last)
                begin
                    if (seeded_reg)
                    begin
                        blend_start = 1'b1;
                        state_next  = ST_BLEND;
                    end
                    else
                    begin
                        avg_next    = med_fx;
                        seeded_next = 1'b1;
                        state_next  = ST_EMIT;
                    end
                end
                else
                begin
                    cand_next = cand_reg + IDX_W'(1);
                end
            end
            ST_BLEND:
            begin
                if (blend_done)
                begin
                    avg_next   = blend_result;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next  = 1'b1;
                    weight_next     = OUT_BITS'(avg_reg[AVG_W-1:FRACTION_BITS]);
                    out_rej_next    = rej_reg;
                    out_seeded_next = seeded_reg;
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wpos_reg      <= '0;
            fill_reg      <= '0;
            cand_reg      <= '0;
            avg_reg       <= '0;
            seeded_reg    <= 1'b0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            cand_reg      <= cand_next;
            avg_reg       <= avg_next;
            seeded_reg    <= seeded_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg     <= weight_next;
        out_rej_reg    <= out_rej_next;
        out_seeded_reg <= out_seeded_next;
        if (ring_we)
            ring_reg[wpos_reg] <= q_value;
    end

    assign result_valid    = out_valid_reg;
    assign filtered_weight = weight_reg;
    assign sample_rejected = out_rej_reg;
    assign average_valid   = out_seeded_reg;

endmodule

### sv/median_ema_weight_filter.sv
// Channel   Direction  Handshake                   Payload
// config    in/out     psel/penable/pwrite, pready paddr, pwdata, prdata
// sample    in         sample_valid/sample_stall   command, raw_sample
// result    out        result_valid/result_stall   filtered_weight, sample_rejected,
//                                                  average_valid
//
// One request at a time in the back end. A feed tests r (1..WINDOW) candidates in the
// median rank scan before it hits, then builds the blend product in NCH 16-bit steps,
// where NCH = ceil((SAMPLE_BITS+FRACTION_BITS+1)/16); the first feed after reset or a
// clear skips the blend.
// Clear and rejected samples skip both. A two-entry queue holds requests while the
// back end works. rst_n is asynchronous; it empties the queue, unseeds the average and
// restores the register defaults. A stalled result holds in the output register while
// the back end finishes the next request behind it.
module median_ema_weight_filter
    import mewf_pkg::*;
#(
    parameter int WINDOW        = DEF_WINDOW,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [BUS_BITS-1:0]           pwdata,
    output logic [BUS_BITS-1:0]           prdata,
    output logic                          pready,
    // sample requests
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic                          command,
    input  logic signed [SAMPLE_BITS-1:0] raw_sample,
    // results
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [OUT_BITS-1:0]           filtered_weight,
    output logic                          sample_rejected,
    output logic                          average_valid
);

    logic signed [SAMPLE_BITS-1:0] tare_reg;
    logic [ALPHA_BITS-1:0]         alpha_reg;
    logic                          cfg_write;

    logic                          q_valid;
    logic                          q_take;
    op_t                           q_op;
    logic [SAMPLE_BITS-1:0]        q_value;

    // register file: word select on paddr[2], byte lane bits ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg  <= '0;
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TARE:  tare_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_ALPHA: alpha_reg <= pwdata[ALPHA_BITS-1:0];
            endcase
        end
    end

    // tare reads back sign-extended
    always_comb
    begin
        unique case (paddr[2])
            REG_TARE:  prdata = BUS_BITS'(tare_reg);
            REG_ALPHA: prdata = BUS_BITS'(alpha_reg);
        endcase
    end

    // front end: tare subtraction, sign check, request queue
    mewf_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .command      (command),
        .raw_sample   (raw_sample),
        .tare_offset  (tare_reg),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .q_op         (q_op),
        .q_value      (q_value)
    );

    // back end: ring, median rank scan, EMA blend, result register
    mewf_back #(
        .WINDOW        (WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_take          (q_take),
        .q_op            (q_op),
        .q_value         (q_value),
        .alpha           (alpha_reg),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .filtered_weight (filtered_weight),
        .sample_rejected (sample_rejected),
        .average_valid   (average_valid)
    );

endmodule

### sv/mewf_checker.sv
module mewf_checker
    import mewf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input logic [OUT_BITS-1:0] filtered_weight,
    input logic                sample_rejected,
    input logic                average_valid
);

    logic [OUT_BITS-1:0] last_weight_reg;
    logic                last_valid_reg;

    // last result handed over; reset state reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_weight_reg <= '0;
            last_valid_reg  <= 1'b0;
        end
        else if (result_valid && !result_stall)
        begin
            last_weight_reg <= filtered_weight;
            last_valid_reg  <= average_valid;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(filtered_weight)
            && $stable(sample_rejected) && $stable(average_valid))
        else $error("stalled result changed");

    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !average_valid |-> filtered_weight == '0)
        else $error("weight reported without a seeded average");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sample_rejected |->
            filtered_weight == last_weight_reg && average_valid == last_valid_reg)
        else $error("rejected sample changed the average");

endmodule

bind median_ema_weight_filter mewf_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .filtered_weight (filtered_weight),
    .sample_rejected (sample_rejected),
    .average_valid   (average_valid)
);

### tb/sv/median_ema_weight_filter_tb.sv
`timescale 1ns / 1ps

module median_ema_weight_filter_tb;
    import mewf_pkg::*;

    localparam int WINDOW        = DEF_WINDOW;
    localparam int SAMPLE_BITS   = DEF_SAMPLE_BITS;
    localparam int FRACTION_BITS = DEF_FRACTION_BITS;

    // byte addresses of the two registers on the config bus
    localparam logic [ADDR_BITS-1:0] ADDR_TARE  = {REG_TARE, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_ALPHA = {REG_ALPHA, 2'b00};

    // request command codes
    localparam logic CMD_FEED  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam int SAMPLE_MIN = -(1 <<< (SAMPLE_BITS - 1));
    localparam int SAMPLE_MAX = (1 <<< (SAMPLE_BITS - 1)) - 1;

    // quiet cycles tolerated before the run is declared hung; set well above the long
    // receiver hold-off, and everything else is far shorter
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 16;

    typedef struct packed {
        logic [OUT_BITS-1:0] weight;
        logic                rejected;
        logic                seeded;
    } weight_result_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ADDR_BITS-1:0]          paddr = '0;
    logic [BUS_BITS-1:0]           pwdata = '0;
    logic [BUS_BITS-1:0]           prdata;
    logic                          pready;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic                          command = CMD_FEED;
    logic signed [SAMPLE_BITS-1:0] raw_sample = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [OUT_BITS-1:0]           filtered_weight;
    logic                          sample_rejected;
    logic                          average_valid;

    median_ema_weight_filter u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .command         (command),
        .raw_sample      (raw_sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .filtered_weight (filtered_weight),
        .sample_rejected (sample_rejected),
        .average_valid   (average_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Filter predictor: own copy of the registers and the filter state,
    // advanced once per accepted request.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] tare_reg = '0;
    logic [ALPHA_BITS-1:0]         alpha_reg = ALPHA_RESET;
    logic [SAMPLE_BITS-1:0]        ring [WINDOW];
    int unsigned                   ring_pos = 0;
    int unsigned                   ring_fill = 0;
    logic [63:0]                   ema_acc = '0;   // average, FRACTION_BITS fraction bits
    logic                          ema_seeded = 1'b0;

    weight_result_t weight_expected [$];
    int             fault_count = 0;

    task automatic predict_weight(input logic cmd, input logic signed [SAMPLE_BITS-1:0] raw);
        int                     corrected;
        logic [SAMPLE_BITS-1:0] sorted [WINDOW];
        logic [SAMPLE_BITS-1:0] key;
        logic [63:0]            med;
        logic [63:0]            wgt;
        int                     j;
        weight_result_t         res;
        res.rejected = 1'b0;
        if (cmd == CMD_CLEAR)
        begin
            // clear empties the ring and unseeds the average
            foreach (ring[i]) ring[i] = '0;
            ring_pos   = 0;
            ring_fill  = 0;
            ema_acc    = '0;
            ema_seeded = 1'b0;
        end
        else
        begin
            corrected = int'(raw) - int'(tare_reg);
            if (corrected < 0)
                res.rejected = 1'b1;   // dropped, state untouched
            else
            begin
                ring[ring_pos] = corrected[SAMPLE_BITS-1:0];
                ring_pos = (ring_pos + 1) % WINDOW;
                if (ring_fill < WINDOW)
                    ring_fill++;
                // insertion sort of the filled entries, pick rank floor(n/2)
                for (int i = 0; i < ring_fill; i++)
                    sorted[i] = ring[i];
                for (int i = 1; i < ring_fill; i++)
                begin
                    key = sorted[i];
                    j = i;
                    while (j > 0 && sorted[j-1] > key)
                    begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = key;
                end
                med = 64'(sorted[ring_fill / 2]) << FRACTION_BITS;
                if (!ema_seeded)
                begin
                    ema_acc    = med;
                    ema_seeded = 1'b1;
                end
                else
                begin
                    // alpha above 1.0 saturates
                    wgt = (alpha_reg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_reg);
                    ema_acc = (wgt * med + (64'(ALPHA_ONE) - wgt) * ema_acc) >> 16;
                end
            end
        end
        res.weight = ema_acc[FRACTION_BITS +: OUT_BITS];
        res.seeded = ema_seeded;
        weight_expected.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Request side: bursts of random length, random gaps between them.
    // ------------------------------------------------------------------
    bit gaps_on = 1'b1;
    int burst_left = 0;

    task automatic send_request(input logic cmd, input logic signed [SAMPLE_BITS-1:0] raw);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        sample_valid <= 1'b1;
        command      <= cmd;
        raw_sample   <= raw;
        do @(posedge clk); while (sample_stall);
        predict_weight(cmd, raw);
    endtask

    // drop valid, wait for every pending result, then let the back end settle
    task automatic wait_idle();
        sample_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (weight_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access; the predictor copy follows the write
    task automatic write_register(input logic [ADDR_BITS-1:0] addr,
                                  input logic [BUS_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TARE)
            tare_reg = data[SAMPLE_BITS-1:0];
        else
            alpha_reg = data[ALPHA_BITS-1:0];
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: alternating stall / free runs, optional long hold-off.
    // ------------------------------------------------------------------
    bit stalls_on = 1'b1;
    int holdoff_ask = 0;
    int holdoff_left = 0;
    int stall_run = 0;
    bit stall_phase = 1'b0;

    always @(posedge clk)
    begin
        if (holdoff_ask != 0)
        begin
            holdoff_left = holdoff_ask;
            holdoff_ask = 0;
        end
        if (holdoff_left != 0)
        begin
            holdoff_left--;
            result_stall <= 1'b1;
        end
        else if (!stalls_on)
            result_stall <= 1'b0;
        else
        begin
            if (stall_run == 0)
            begin
                stall_phase = !stall_phase;
                stall_run = stall_phase ? $urandom_range(1, 6) : $urandom_range(1, 14);
            end
            stall_run--;
            result_stall <= stall_phase;
        end
    end

    // compare each accepted result with the oldest pending prediction
    always @(posedge clk)
    begin
        weight_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (weight_expected.size() == 0)
            begin
                $display("%0t: unexpected result weight=%0d rejected=%0b seeded=%0b",
                         $time, filtered_weight, sample_rejected, average_valid);
                fault_count++;
            end
            else
            begin
                want = weight_expected.pop_front();
                if (filtered_weight !== want.weight)
                begin
                    $display("%0t: filtered_weight expected %0d actual %0d",
                             $time, want.weight, filtered_weight);
                    fault_count++;
                end
                if (sample_rejected !== want.rejected)
                begin
                    $display("%0t: sample_rejected expected %0b actual %0b",
                             $time, want.rejected, sample_rejected);
                    fault_count++;
                end
                if (average_valid !== want.seeded)
                begin
                    $display("%0t: average_valid expected %0b actual %0b",
                             $time, want.seeded, average_valid);
                    fault_count++;
                end
            end
        end
    end

    // hang detector: nothing moving on any port for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Random sample picker: mostly just above the tare so the ring fills
    // and the average moves, some below it (rejected), some anywhere, others at the extremes.
    // ------------------------------------------------------------------
    int sample_span = 1000;

    function automatic logic signed [SAMPLE_BITS-1:0] pick_raw();
        int          roll;
        int          val;
        logic [31:0] bits;
        roll = $urandom_range(0, 99);
        bits = $urandom();
        if (roll < 70)
            val = int'(tare_reg) + $urandom_range(0, sample_span);
        else if (roll < 85)
            val = int'(tare_reg) - $urandom_range(1, 2000);
        else if (roll < 95)
            return bits[SAMPLE_BITS-1:0];
        else
            val = bits[0] ? SAMPLE_MAX : SAMPLE_MIN;
        if (val > SAMPLE_MAX)
            val = SAMPLE_MAX;
        if (val < SAMPLE_MIN)
            val = SAMPLE_MIN;
        return val[SAMPLE_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset defaults: rejects while unseeded, clear on an empty filter,
    // sample extremes, ring wrap past WINDOW entries, reseed after clear
    task automatic test_corner_samples();
        send_request(CMD_FEED, -1);
        send_request(CMD_CLEAR, SAMPLE_MAX);
        send_request(CMD_FEED, SAMPLE_MAX);
        send_request(CMD_FEED, 0);
        send_request(CMD_FEED, SAMPLE_MIN);
        send_request(CMD_FEED, 100);
        send_request(CMD_FEED, 200);
        send_request(CMD_FEED, 300);
        send_request(CMD_FEED, 50);
        send_request(CMD_FEED, 70000);
        send_request(CMD_CLEAR, SAMPLE_MIN);
        send_request(CMD_FEED, 7);
        wait_idle();
    endtask

    // register extremes: widest corrected value, alpha of 0, 1.0 and
    // above 1.0, highest tare where only one code survives
    task automatic test_register_extremes();
        write_register(ADDR_TARE, SAMPLE_MIN);
        write_register(ADDR_ALPHA, ALPHA_ONE);
        send_request(CMD_CLEAR, 0);
        send_request(CMD_FEED, SAMPLE_MIN);
        send_request(CMD_FEED, SAMPLE_MAX);
        wait_idle();
        write_register(ADDR_ALPHA, 0);
        send_request(CMD_FEED, 5);
        wait_idle();
        write_register(ADDR_ALPHA, {ALPHA_BITS{1'b1}});
        send_request(CMD_FEED, 0);
        wait_idle();
        write_register(ADDR_TARE, SAMPLE_MAX);
        write_register(ADDR_ALPHA, 1);
        send_request(CMD_CLEAR, 0);
        send_request(CMD_FEED, SAMPLE_MAX);
        send_request(CMD_FEED, SAMPLE_MAX - 1);
        send_request(CMD_FEED, SAMPLE_MIN);
        wait_idle();
    endtask

    // one phase of random traffic under a fresh random setting
    task automatic test_random_traffic(input int count, input bit with_gaps,
                                       input bit with_stalls);
        logic [31:0] bits;
        int          alpha_pick;
        bits = $urandom();
        case ($urandom_range(0, 3))
            0:       write_register(ADDR_TARE, 0);
            1:       write_register(ADDR_TARE, $urandom_range(0, 20000) - 10000);
            2:       write_register(ADDR_TARE, {{8{bits[23]}}, bits[23:0]});
            default: write_register(ADDR_TARE, bits[0] ? SAMPLE_MIN : SAMPLE_MAX - 5000);
        endcase
        case ($urandom_range(0, 4))
            0:       alpha_pick = 0;
            1:       alpha_pick = ALPHA_ONE;
            2:       alpha_pick = $urandom_range(ALPHA_ONE + 1, (1 << ALPHA_BITS) - 1);
            3:       alpha_pick = ALPHA_RESET;
            default: alpha_pick = $urandom_range(0, ALPHA_ONE);
        endcase
        write_register(ADDR_ALPHA, alpha_pick);
        sample_span = $urandom_range(0, 1) ? 1000 : SAMPLE_MAX;
        gaps_on   = with_gaps;
        stalls_on = with_stalls;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 3)
                send_request(CMD_CLEAR, pick_raw());
            else
                send_request(CMD_FEED, pick_raw());
        end
        wait_idle();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // receiver holds off for a long stretch while requests keep coming,
    // so the queue fills and sample_stall has to rise
    task automatic test_backpressure();
        gaps_on = 1'b0;
        holdoff_ask = 300;
        for (int n = 0; n < 40; n++)
            send_request(CMD_FEED, pick_raw());
        wait_idle();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_samples();
        test_register_extremes();
        for (int p = 0; p < 4; p++)
            test_random_traffic(150, 1'b1, 1'b1);
        test_random_traffic(150, 1'b0, 1'b0);
        test_backpressure();
        test_random_traffic(150, 1'b1, 1'b1);
        wait_idle();
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
